@@ rtl/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared widths, item types and control bundles of the complex T to pi
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctp_pkg;

  // Q format of every element word
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // delta = AB + BC + CA at full precision: six products plus sign headroom
  localparam int DLT_W   = 2 * WORD_BITS + 3;
  // |delta|^2 from two delta magnitudes
  localparam int MAG2_W  = 2 * DLT_W;
  // one element magnitude times one delta magnitude
  localparam int XD_W    = WORD_BITS + DLT_W;
  // signed numerator X * conj(delta), one part
  localparam int NUM_W   = XD_W + 1;
  // 2 * |numerator| << 2F
  localparam int SHN_W   = NUM_W + 2 * FRAC_BITS + 1;
  // dividend and divisor of the rounding division
  localparam int DIVD_W  = ((SHN_W > MAG2_W) ? SHN_W : MAG2_W) + 1;
  // trial subtraction width in the divider
  localparam int EXT_W   = DIVD_W + WORD_BITS + 1;

  localparam int LANES   = 3;
  localparam int QUOTS   = 2 * LANES;

  // digit width of the partial-product multipliers
  localparam int DIGIT_W = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [DIVD_W-1:0]           divd_t;

  typedef struct packed {
    logic  func;
    word_t a_re;
    word_t a_im;
    word_t b_re;
    word_t b_im;
    word_t c_re;
    word_t c_im;
  } in_item_t;

  typedef struct packed {
    word_t out1_re;
    word_t out1_im;
    word_t out2_re;
    word_t out2_im;
    word_t out3_re;
    word_t out3_im;
    logic  degenerate;
  } out_item_t;

  // control that travels with the dividends into the divider
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic [QUOTS-1:0] neg;
  } quot_ctl_t;

endpackage

@@ rtl/ctp_umul.sv @@
// ----------------------------------------------------------------------------
// ctp_umul
// Two-stage unsigned multiplier: digit partial products, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_umul import ctp_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  localparam int NA  = (A_W + DIGIT_W - 1) / DIGIT_W;
  localparam int NB  = (B_W + DIGIT_W - 1) / DIGIT_W;
  localparam int P_W = A_W + B_W;

  logic [NA*DIGIT_W-1:0] a_pad;
  logic [NB*DIGIT_W-1:0] b_pad;
  logic [2*DIGIT_W-1:0]  pp_q [NA][NB];
  logic [P_W-1:0]        sum_d;
  logic [P_W-1:0]        p_q;

  assign a_pad = (NA*DIGIT_W)'(a_i);
  assign b_pad = (NB*DIGIT_W)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_pad[i*DIGIT_W +: DIGIT_W] * b_pad[j*DIGIT_W +: DIGIT_W];
        end
      end
    end
  end

  // the product fits P_W bits, so sums modulo 2^P_W are exact
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (P_W'(pp_q[i][j]) << (DIGIT_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/ctp_front.sv @@
// ----------------------------------------------------------------------------
// ctp_front
// Eight-stage front end: delta, |delta|^2, numerators X * conj(delta) and
// the rounding dividends for the six quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_front import ctp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  in_item_t                item_i,
  output quot_ctl_t               ctl_o,
  output divd_t                   den_o,
  output divd_t [QUOTS-1:0]       num_o
);

  typedef logic signed [2*WORD_BITS-1:0] prod_t;
  typedef logic signed [DLT_W-1:0]       dlt_t;
  typedef logic signed [NUM_W-1:0]       num_t;

  function automatic num_t apply_sign(logic [XD_W-1:0] mag, logic neg);
    num_t t;
    t = num_t'(mag);
    return neg ? -t : t;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  // stage 1
  prod_t pr1_q [6];
  prod_t pi1_q [6];
  word_t xr1_q [LANES];
  word_t xi1_q [LANES];
  // stage 2
  dlt_t  dr2_q, di2_q;
  word_t xr2_q [LANES];
  word_t xi2_q [LANES];
  // stage 3
  logic [DLT_W-1:0]     drm3_q, dim3_q;
  logic [WORD_BITS-1:0] xrm3_q [LANES];
  logic [WORD_BITS-1:0] xim3_q [LANES];
  logic [3:0]           sg3_q  [LANES];
  logic                 dg3_q;
  // stages 4 and 5 (inside the multipliers)
  logic [3:0]           sg4_q [LANES];
  logic [3:0]           sg5_q [LANES];
  logic                 dg4_q, dg5_q;
  logic [MAG2_W-1:0]    p_dd, p_ee;
  logic [XD_W-1:0]      p_rr [LANES];
  logic [XD_W-1:0]      p_ii [LANES];
  logic [XD_W-1:0]      p_ir [LANES];
  logic [XD_W-1:0]      p_ri [LANES];
  // stage 6
  logic [MAG2_W-1:0]    m6_q;
  num_t                 n6_q [QUOTS];
  logic                 dg6_q;
  // stage 7
  logic [MAG2_W-1:0]    m7_q;
  logic [NUM_W-1:0]     nm7_q [QUOTS];
  logic [QUOTS-1:0]     ng7_q;
  logic                 dg7_q;
  // stage 8
  divd_t                num8_q [QUOTS];
  divd_t                den8_q;
  logic [QUOTS-1:0]     ng8_q;
  logic                 dg8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <= '0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: the twelve element products, pick the elements to divide
      pr1_q[0] <= item_i.a_re * item_i.b_re;
      pr1_q[1] <= item_i.a_im * item_i.b_im;
      pr1_q[2] <= item_i.b_re * item_i.c_re;
      pr1_q[3] <= item_i.b_im * item_i.c_im;
      pr1_q[4] <= item_i.c_re * item_i.a_re;
      pr1_q[5] <= item_i.c_im * item_i.a_im;
      pi1_q[0] <= item_i.a_re * item_i.b_im;
      pi1_q[1] <= item_i.a_im * item_i.b_re;
      pi1_q[2] <= item_i.b_re * item_i.c_im;
      pi1_q[3] <= item_i.b_im * item_i.c_re;
      pi1_q[4] <= item_i.c_re * item_i.a_im;
      pi1_q[5] <= item_i.c_im * item_i.a_re;
      if (item_i.func) begin
        xr1_q[0] <= item_i.b_re; xi1_q[0] <= item_i.b_im;
        xr1_q[1] <= item_i.c_re; xi1_q[1] <= item_i.c_im;
        xr1_q[2] <= item_i.a_re; xi1_q[2] <= item_i.a_im;
      end else begin
        xr1_q[0] <= item_i.c_re; xi1_q[0] <= item_i.c_im;
        xr1_q[1] <= item_i.a_re; xi1_q[1] <= item_i.a_im;
        xr1_q[2] <= item_i.b_re; xi1_q[2] <= item_i.b_im;
      end

      // stage 2: delta
      dr2_q <= dlt_t'(pr1_q[0]) - dlt_t'(pr1_q[1]) + dlt_t'(pr1_q[2])
             - dlt_t'(pr1_q[3]) + dlt_t'(pr1_q[4]) - dlt_t'(pr1_q[5]);
      di2_q <= dlt_t'(pi1_q[0]) + dlt_t'(pi1_q[1]) + dlt_t'(pi1_q[2])
             + dlt_t'(pi1_q[3]) + dlt_t'(pi1_q[4]) + dlt_t'(pi1_q[5]);
      xr2_q <= xr1_q;
      xi2_q <= xi1_q;

      // stage 3: magnitudes and product signs, zero delta detect
      drm3_q <= dr2_q[DLT_W-1] ? DLT_W'(-dr2_q) : DLT_W'(dr2_q);
      dim3_q <= di2_q[DLT_W-1] ? DLT_W'(-di2_q) : DLT_W'(di2_q);
      dg3_q  <= (dr2_q == '0) && (di2_q == '0);
      for (int k = 0; k < LANES; k++) begin
        xrm3_q[k] <= xr2_q[k][WORD_BITS-1] ? WORD_BITS'(-xr2_q[k]) : WORD_BITS'(xr2_q[k]);
        xim3_q[k] <= xi2_q[k][WORD_BITS-1] ? WORD_BITS'(-xi2_q[k]) : WORD_BITS'(xi2_q[k]);
        // signs of xr*dr, xi*di, xi*dr, xr*di
        sg3_q[k]  <= {xr2_q[k][WORD_BITS-1] ^ di2_q[DLT_W-1],
                      xi2_q[k][WORD_BITS-1] ^ dr2_q[DLT_W-1],
                      xi2_q[k][WORD_BITS-1] ^ di2_q[DLT_W-1],
                      xr2_q[k][WORD_BITS-1] ^ dr2_q[DLT_W-1]};
      end

      // stages 4 and 5: carry signs alongside the multipliers
      sg4_q <= sg3_q;
      sg5_q <= sg4_q;
      dg4_q <= dg3_q;
      dg5_q <= dg4_q;

      // stage 6: |delta|^2 and the signed numerators
      m6_q <= p_dd + p_ee;
      for (int k = 0; k < LANES; k++) begin
        n6_q[2*k]   <= apply_sign(p_rr[k], sg5_q[k][0]) + apply_sign(p_ii[k], sg5_q[k][1]);
        n6_q[2*k+1] <= apply_sign(p_ir[k], sg5_q[k][2]) - apply_sign(p_ri[k], sg5_q[k][3]);
      end
      dg6_q <= dg5_q;

      // stage 7: numerator magnitudes
      m7_q <= m6_q;
      for (int q = 0; q < QUOTS; q++) begin
        ng7_q[q] <= n6_q[q][NUM_W-1];
        nm7_q[q] <= n6_q[q][NUM_W-1] ? NUM_W'(-n6_q[q]) : NUM_W'(n6_q[q]);
      end
      dg7_q <= dg6_q;

      // stage 8: dividend 2|n|*2^2F + m, divisor 2m (round half away)
      for (int q = 0; q < QUOTS; q++) begin
        num8_q[q] <= (DIVD_W'(nm7_q[q]) << (2 * FRAC_BITS + 1)) + DIVD_W'(m7_q);
      end
      den8_q <= DIVD_W'(m7_q) << 1;
      ng8_q  <= ng7_q;
      dg8_q  <= dg7_q;
    end
  end

  ctp_umul #(.A_W(DLT_W), .B_W(DLT_W)) u_mul_dd (
    .clk_i, .en_i, .a_i(drm3_q), .b_i(drm3_q), .p_o(p_dd)
  );

  ctp_umul #(.A_W(DLT_W), .B_W(DLT_W)) u_mul_ee (
    .clk_i, .en_i, .a_i(dim3_q), .b_i(dim3_q), .p_o(p_ee)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    ctp_umul #(.A_W(WORD_BITS), .B_W(DLT_W)) u_mul_rr (
      .clk_i, .en_i, .a_i(xrm3_q[k]), .b_i(drm3_q), .p_o(p_rr[k])
    );
    ctp_umul #(.A_W(WORD_BITS), .B_W(DLT_W)) u_mul_ii (
      .clk_i, .en_i, .a_i(xim3_q[k]), .b_i(dim3_q), .p_o(p_ii[k])
    );
    ctp_umul #(.A_W(WORD_BITS), .B_W(DLT_W)) u_mul_ir (
      .clk_i, .en_i, .a_i(xim3_q[k]), .b_i(drm3_q), .p_o(p_ir[k])
    );
    ctp_umul #(.A_W(WORD_BITS), .B_W(DLT_W)) u_mul_ri (
      .clk_i, .en_i, .a_i(xrm3_q[k]), .b_i(dim3_q), .p_o(p_ri[k])
    );
  end

  assign ctl_o = '{valid: v8_q, degen: dg8_q, neg: ng8_q};
  assign den_o = den8_q;

  always_comb begin
    for (int q = 0; q < QUOTS; q++) begin
      num_o[q] = num8_q[q];
    end
  end

endmodule

@@ rtl/ctp_div.sv @@
// ----------------------------------------------------------------------------
// ctp_div
// Pipelined restoring divider, one quotient bit per stage for six lanes
// sharing one divisor, then saturation, sign and zero-delta override.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_div import ctp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  quot_ctl_t         ctl_i,
  input  divd_t             den_i,
  input  divd_t [QUOTS-1:0] num_i,
  output logic              valid_o,
  output out_item_t         item_o
);

  typedef logic [EXT_W-1:0] ext_t;

  // stage 0 checks overflow, stages 1..WORD_BITS resolve one bit each
  divd_t                rem_q [0:WORD_BITS-1][QUOTS];
  divd_t                den_q [0:WORD_BITS-1];
  logic [WORD_BITS-1:0] quo_q [0:WORD_BITS][QUOTS];
  logic [QUOTS-1:0]     ovf_q [0:WORD_BITS];
  logic [QUOTS-1:0]     neg_q [0:WORD_BITS];
  logic                 dg_q  [0:WORD_BITS];
  logic                 v_q   [0:WORD_BITS];

  ext_t                 trial [1:WORD_BITS][QUOTS];
  logic [WORD_BITS-1:0] res   [QUOTS];
  out_item_t            fin_d, fin_q;
  logic                 fin_v_q;

  always_comb begin
    for (int s = 1; s <= WORD_BITS; s++) begin
      for (int q = 0; q < QUOTS; q++) begin
        trial[s][q] = ext_t'(rem_q[s-1][q]) - (ext_t'(den_q[s-1]) << (WORD_BITS - s));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= WORD_BITS; s++) begin
        v_q[s] <= 1'b0;
      end
      fin_v_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= ctl_i.valid;
      for (int s = 1; s <= WORD_BITS; s++) begin
        v_q[s] <= v_q[s-1];
      end
      fin_v_q <= v_q[WORD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int q = 0; q < QUOTS; q++) begin
        rem_q[0][q] <= num_i[q];
        quo_q[0][q] <= '0;
        ovf_q[0][q] <= ext_t'(num_i[q]) >= (ext_t'(den_i) << WORD_BITS);
      end
      den_q[0] <= den_i;
      neg_q[0] <= ctl_i.neg;
      dg_q[0]  <= ctl_i.degen;

      for (int s = 1; s < WORD_BITS; s++) begin
        for (int q = 0; q < QUOTS; q++) begin
          rem_q[s][q] <= trial[s][q][EXT_W-1] ? rem_q[s-1][q] : trial[s][q][DIVD_W-1:0];
        end
        den_q[s] <= den_q[s-1];
      end

      for (int s = 1; s <= WORD_BITS; s++) begin
        for (int q = 0; q < QUOTS; q++) begin
          quo_q[s][q] <= quo_q[s-1][q]
                       | (WORD_BITS'(!trial[s][q][EXT_W-1]) << (WORD_BITS - s));
        end
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
        dg_q[s]  <= dg_q[s-1];
      end

      fin_q <= fin_d;
    end
  end

  // clamp the magnitude to the word range, then apply the sign
  always_comb begin
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] mag;
    for (int q = 0; q < QUOTS; q++) begin
      lim = (WORD_BITS'(1) << (WORD_BITS - 1)) - WORD_BITS'(!neg_q[WORD_BITS][q]);
      mag = (ovf_q[WORD_BITS][q] || (quo_q[WORD_BITS][q] > lim)) ? lim
                                                                 : quo_q[WORD_BITS][q];
      if (dg_q[WORD_BITS]) begin
        res[q] = '0;
      end else begin
        res[q] = neg_q[WORD_BITS][q] ? -mag : mag;
      end
    end
    fin_d.out1_re    = res[0];
    fin_d.out1_im    = res[1];
    fin_d.out2_re    = res[2];
    fin_d.out2_im    = res[3];
    fin_d.out3_re    = res[4];
    fin_d.out3_im    = res[5];
    fin_d.degenerate = dg_q[WORD_BITS];
  end

  assign valid_o = fin_v_q;
  assign item_o  = fin_q;

endmodule

@@ rtl/complex_t_pi_convert_top.sv @@
// ----------------------------------------------------------------------------
// complex_t_pi_convert_top
// Throughput: one item per cycle while in_stall_o is low; the divider
//   resolves one quotient bit per stage, so its WORD_BITS + 2 stages set
//   most of the latency.
// Reset: rst_ni (async, low) clears every valid bit; no item is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_t_pi_convert_top import ctp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Whole pipeline advances together. It freezes only when the skid slot
  // holds an item, i.e. the output register was full and stalled while a
  // new result arrived. Both are registers, so stall never races the pipe.
  logic      adv;
  logic      in_v_q;
  in_item_t  in_q;
  quot_ctl_t fr_ctl;
  divd_t     fr_den;
  divd_t [QUOTS-1:0] fr_num;
  logic      dv_valid;
  out_item_t dv_item;
  logic      out_v_q, skid_v_q, out_free;
  out_item_t out_q, skid_q;

  assign adv      = ~skid_v_q;
  assign out_free = ~out_v_q | ~out_stall_i;

  // Capture the input item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Delta, |delta|^2 and dividends.
  ctp_front u_front (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (in_v_q),
    .item_i  (in_q),
    .ctl_o   (fr_ctl),
    .den_o   (fr_den),
    .num_o   (fr_num)
  );

  // Bit-per-stage division, rounding and saturation.
  ctp_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .ctl_i   (fr_ctl),
    .den_i   (fr_den),
    .num_i   (fr_num),
    .valid_o (dv_valid),
    .item_o  (dv_item)
  );

  // Output register plus skid slot. Drain the skid first; otherwise take
  // the pipe's result into the output, or park it when the output is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (dv_valid) begin
      if (out_free) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (dv_valid) begin
      if (out_free) begin
        out_q <= dv_item;
      end else begin
        skid_q <= dv_item;
      end
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/ctp_checker.sv @@
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks of the T to pi converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctp_checker import ctp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a degenerate item carries all-zero elements
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.out1_re == '0 && out_data_o.out1_im == '0 &&
      out_data_o.out2_re == '0 && out_data_o.out2_im == '0 &&
      out_data_o.out3_re == '0 && out_data_o.out3_im == '0)
    else $error("degenerate item with nonzero elements");

  // input stall only follows a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  // while input is stalled the output register is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held output item changed");

endmodule

bind complex_t_pi_convert_top ctp_checker u_ctp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
